[design/lsmwf_pkg.sv]
// Shared types and constants of the line sync minimum window finder.
package lsmwf_pkg;

  localparam int unsigned WINDOW  = 38;
  localparam int unsigned FILL_W  = $clog2(WINDOW);
  localparam int unsigned SMP_W   = 8;
  localparam int unsigned SUM_W   = 14;
  localparam int unsigned OFF_W   = 12;
  localparam int unsigned POS_W   = 13;
  localparam int unsigned LINE_W  = 24;

  typedef logic [SMP_W-1:0]  sample_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [OFF_W-1:0]  off_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [LINE_W-1:0] line_t;
  typedef logic [FILL_W-1:0] fill_t;

  localparam sum_t  SUM_MAX    = '1;
  localparam off_t  OFF_MAX    = '1;
  localparam pos_t  LEN_RESET  = POS_W'(512);
  localparam fill_t FILL_LAST  = FILL_W'(WINDOW - 1);
  localparam sum_t  SUM_BOUND  = SUM_W'(WINDOW * 255);

  typedef struct packed {
    logic full;
    sum_t sum;
  } win_t;

endpackage

[design/lsmwf_if.sv]
// Handshake channel interfaces for sample items, result items and configuration.
interface lsmwf_in_if;
  logic                   valid;
  logic                   ready;
  lsmwf_pkg::sample_t     sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface lsmwf_out_if;
  logic                   valid;
  logic                   ready;
  lsmwf_pkg::line_t       line_number;
  lsmwf_pkg::pos_t        sync_position;
  lsmwf_pkg::sum_t        minimum_sum;
  modport source (output valid, output line_number, output sync_position,
                  output minimum_sum, input ready);
  modport sink   (input valid, input line_number, input sync_position,
                  input minimum_sum, output ready);
endinterface

interface lsmwf_cfg_if;
  logic                   valid;
  logic                   ready;
  lsmwf_pkg::pos_t        line_length;
  modport source (output valid, output line_length, input ready);
  modport sink   (input valid, input line_length, output ready);
endinterface

[design/lsmwf_window.sv]
// Sample delay line with running window sum and fill tracking.
module lsmwf_window (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  lsmwf_pkg::sample_t sample_i,
  output lsmwf_pkg::win_t    win_o
);
  import lsmwf_pkg::*;

  sample_t dly_q [WINDOW];
  sum_t    sum_q, sum_d;
  fill_t   fill_q, fill_d;

  always_comb begin
    sum_d  = sum_q + SUM_W'(sample_i) - SUM_W'(dly_q[WINDOW-1]);
    fill_d = (fill_q == FILL_LAST) ? fill_q : fill_q + FILL_W'(1);
  end

  assign win_o.full = (fill_q == FILL_LAST);
  assign win_o.sum  = sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) dly_q[i] <= '0;
      sum_q  <= '0;
      fill_q <= '0;
    end else if (accept_i) begin
      dly_q[0] <= sample_i;
      for (int i = 1; i < WINDOW; i++) dly_q[i] <= dly_q[i-1];
      sum_q  <= sum_d;
      fill_q <= fill_d;
    end
  end

endmodule

[design/line_sync_min_window_finder_top.sv]
// Top level of the line sync minimum window finder.
// Latency: a result appears in the cycle after the item that ends its line.
// Throughput: one sample item per cycle, set by the single add, subtract and compare.
// The input stalls only while a result waits in the output register.
// Reset clears the window and counters and sets the best sum to its maximum; line length returns to 512.
module line_sync_min_window_finder_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  lsmwf_in_if.sink     sample_i,
  lsmwf_cfg_if.sink    cfg_i,
  lsmwf_out_if.source  result_o
);
  import lsmwf_pkg::*;

  win_t  win;
  logic  accept, take, line_end, emit;
  sum_t  cand_sum;
  off_t  cand_off;
  pos_t  off_p1;

  pos_t  len_q;
  off_t  start_q;
  line_t line_q;
  sum_t  best_sum_q;
  off_t  best_off_q;
  logic  out_valid_q;
  line_t out_line_q;
  pos_t  out_pos_q;
  sum_t  out_sum_q;

  assign sample_i.ready = !out_valid_q || result_o.ready;
  assign accept         = sample_i.valid && sample_i.ready;
  assign cfg_i.ready    = 1'b1;

  lsmwf_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .sample_i (sample_i.sample),
    .win_o    (win)
  );

  always_comb begin
    take     = win.sum < best_sum_q;
    cand_sum = take ? win.sum : best_sum_q;
    cand_off = take ? start_q : best_off_q;
    off_p1   = {1'b0, start_q} + POS_W'(1);
    line_end = (off_p1 >= len_q) || (start_q == OFF_MAX);
    emit     = accept && win.full && line_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_RESET;
    end else if (cfg_i.valid) begin
      len_q <= cfg_i.line_length;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= '0;
      line_q     <= '0;
      best_sum_q <= SUM_MAX;
      best_off_q <= '0;
    end else if (accept && win.full) begin
      if (line_end) begin
        start_q    <= '0;
        line_q     <= line_q + LINE_W'(1);
        best_sum_q <= SUM_MAX;
        best_off_q <= '0;
      end else begin
        start_q    <= start_q + OFF_W'(1);
        best_sum_q <= cand_sum;
        best_off_q <= cand_off;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_line_q <= line_q;
      out_pos_q  <= {1'b0, cand_off} + POS_W'(WINDOW);
      out_sum_q  <= cand_sum;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.line_number   = out_line_q;
  assign result_o.sync_position = out_pos_q;
  assign result_o.minimum_sum   = out_sum_q;

  a_emit_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (start_q == '0) && (best_sum_q == SUM_MAX) && out_valid_q)
    else $error("line end did not restart the search");

  a_line_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> line_q == $past(line_q) + LINE_W'(1))
    else $error("line counter did not advance");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sample_i.ready |-> out_valid_q && !result_o.ready)
    else $error("input stalled without a waiting result");

  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_pos_q >= POS_W'(WINDOW)) && (out_sum_q <= SUM_BOUND))
    else $error("result out of range");

endmodule
